// ----- rtl/rpid_pkg.sv -----
// rpid_pkg: shared types and constants for the ramped PID speed loop.
// Used by rpid_cfg, rpid_ctrl, rpid_dp and the top level. No dependencies.
`default_nettype none

package rpid_pkg;

  localparam int TGT_W   = 15;
  localparam int GAIN_W  = 32;
  localparam int STEP_W  = 8;
  localparam int LIMIT_W = 9;
  localparam int SPEED_W = 18;
  localparam int ERR_W   = 19;
  localparam int DRIVE_W = 10;
  localparam int CMP_W   = 13;
  localparam int IDX_W   = 3;
  localparam int DATA_W  = 32;
  localparam int FRAC_W  = 16;

  localparam logic [IDX_W-1:0] REG_TARGET = 3'd0;
  localparam logic [IDX_W-1:0] REG_KP     = 3'd1;
  localparam logic [IDX_W-1:0] REG_KI     = 3'd2;
  localparam logic [IDX_W-1:0] REG_KD     = 3'd3;
  localparam logic [IDX_W-1:0] REG_STEP   = 3'd4;
  localparam logic [IDX_W-1:0] REG_LIMIT  = 3'd5;

  localparam logic [STEP_W-1:0]  STEP_RESET  = 8'd5;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd450;

  typedef struct packed {
    logic signed [TGT_W-1:0]  target_speed;
    logic signed [GAIN_W-1:0] gain_prop;
    logic signed [GAIN_W-1:0] gain_int_scaled;
    logic signed [GAIN_W-1:0] gain_der_scaled;
    logic [STEP_W-1:0]        ramp_step;
    logic [LIMIT_W-1:0]       drive_limit;
  } cfg_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_KP,
    MUL_KI,
    MUL_KD,
    MUL_NUM,
    MUL_REC,
    MUL_QD
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef struct packed {
    logic     accept;
    logic     err;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     clamp;
    logic     n_load;
    logic     q_load;
    logic     out_load;
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/ramped_pid_speed_loop_hbridge_pwm.sv -----
// Ramped PID speed loop with H-bridge PWM compare outputs. Each request on the
// input channel is one control tick carrying a measured speed; it produces one
// result request. Requests are taken only while idle, and each runs the accepting
// cycle plus eleven sequencer steps, the last of which registers the result. The
// sequencer runs the ramp, error and integral steps, then six
// passes through one shared 33x33 multiplier (three gain products and the
// compare scaling by PWM_TOP/DRIVE_FULL via a reciprocal and correction).
// Results sit in an output register, so a new request is taken while the last
// result waits; a tick stalls at its last step only if that result is still
// unclaimed. Configuration writes complete in the cycle they are presented.
// Depends on rpid_pkg, rpid_cfg, rpid_ctrl and rpid_dp.
`default_nettype none

module ramped_pid_speed_loop_hbridge_pwm #(
  parameter int PWM_TOP    = 7199,
  parameter int DRIVE_FULL = 500
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [rpid_pkg::SPEED_W-1:0] speed_rpm,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [rpid_pkg::DRIVE_W-1:0]      drive_value,
  output logic [rpid_pkg::CMP_W-1:0]               compare_a,
  output logic [rpid_pkg::CMP_W-1:0]               compare_b,
  output logic signed [rpid_pkg::TGT_W-1:0]        ramped_setpoint,
  output logic                                     clamped_flag,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [rpid_pkg::IDX_W-1:0]          cfg_index,
  input  wire logic [rpid_pkg::DATA_W-1:0]         cfg_data
);
  import rpid_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  rpid_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rpid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  rpid_dp #(
    .PWM_TOP    (PWM_TOP),
    .DRIVE_FULL (DRIVE_FULL)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .cmd             (cmd),
    .speed_rpm       (speed_rpm),
    .drive_value     (drive_value),
    .compare_a       (compare_a),
    .compare_b       (compare_b),
    .ramped_setpoint (ramped_setpoint),
    .clamped_flag    (clamped_flag)
  );

endmodule

`default_nettype wire

// ----- rtl/rpid_cfg.sv -----
// rpid_cfg: configuration register bank written over the cfg channel.
// Depends on rpid_pkg for the register map and the cfg_t bundle.
`default_nettype none

module rpid_cfg (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [rpid_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [rpid_pkg::DATA_W-1:0] cfg_data,
  output rpid_pkg::cfg_t                 cfg
);
  import rpid_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_speed    <= '0;
      cfg.gain_prop       <= '0;
      cfg.gain_int_scaled <= '0;
      cfg.gain_der_scaled <= '0;
      cfg.ramp_step       <= STEP_RESET;
      cfg.drive_limit     <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TARGET: cfg.target_speed    <= cfg_data[TGT_W-1:0];
        REG_KP:     cfg.gain_prop       <= cfg_data[GAIN_W-1:0];
        REG_KI:     cfg.gain_int_scaled <= cfg_data[GAIN_W-1:0];
        REG_KD:     cfg.gain_der_scaled <= cfg_data[GAIN_W-1:0];
        REG_STEP:   cfg.ramp_step       <= cfg_data[STEP_W-1:0];
        REG_LIMIT:  cfg.drive_limit     <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rpid_ctrl.sv -----
// rpid_ctrl: sequencer that steps the datapath through one control tick.
// Depends on rpid_pkg for cmd_t; owns the input stall and result valid.
`default_nettype none

module rpid_ctrl (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  output rpid_pkg::cmd_t cmd
);
  import rpid_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_MP,
    S_MI,
    S_MD,
    S_SUM,
    S_CLAMP,
    S_NUM,
    S_REC,
    S_QEST,
    S_QD,
    S_FIX
  } state_t;

  state_t state;
  logic   accept;
  logic   slot_free;

  assign accept    = (state == S_IDLE) && in_valid;
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    cmd          = '0;
    cmd.mul_sel  = MUL_NONE;
    cmd.acc_op   = ACC_HOLD;
    cmd.accept   = accept;
    case (state)
      S_ERR:   cmd.err = 1'b1;
      S_MP:    cmd.mul_sel = MUL_KP;
      S_MI: begin
        cmd.mul_sel = MUL_KI;
        cmd.acc_op  = ACC_LOAD;
      end
      S_MD: begin
        cmd.mul_sel = MUL_KD;
        cmd.acc_op  = ACC_ADD;
      end
      S_SUM:   cmd.acc_op = ACC_ADD;
      S_CLAMP: cmd.clamp = 1'b1;
      S_NUM:   cmd.mul_sel = MUL_NUM;
      S_REC: begin
        cmd.mul_sel = MUL_REC;
        cmd.n_load  = 1'b1;
      end
      S_QEST:  cmd.q_load = 1'b1;
      S_QD:    cmd.mul_sel = MUL_QD;
      S_FIX:   cmd.out_load = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_stall  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_FIX && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state    <= S_ERR;
            in_stall <= 1'b1;
          end
        end
        S_ERR:   state <= S_MP;
        S_MP:    state <= S_MI;
        S_MI:    state <= S_MD;
        S_MD:    state <= S_SUM;
        S_SUM:   state <= S_CLAMP;
        S_CLAMP: state <= S_NUM;
        S_NUM:   state <= S_REC;
        S_REC:   state <= S_QEST;
        S_QEST:  state <= S_QD;
        S_QD:    state <= S_FIX;
        S_FIX: begin
          if (slot_free) begin
            state    <= S_IDLE;
            in_stall <= 1'b0;
          end
        end
        default: begin
          state    <= S_IDLE;
          in_stall <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rpid_dp.sv -----
// rpid_dp: PID datapath with ramp, saturating integral, one shared multiplier,
// clamp and compare mapping. Depends on rpid_pkg; driven by rpid_ctrl commands.
`default_nettype none

module rpid_dp #(
  parameter int PWM_TOP    = 7199,
  parameter int DRIVE_FULL = 500
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire rpid_pkg::cfg_t                    cfg,
  input  wire rpid_pkg::cmd_t                    cmd,
  input  wire logic signed [rpid_pkg::SPEED_W-1:0] speed_rpm,
  output logic signed [rpid_pkg::DRIVE_W-1:0]    drive_value,
  output logic [rpid_pkg::CMP_W-1:0]             compare_a,
  output logic [rpid_pkg::CMP_W-1:0]             compare_b,
  output logic signed [rpid_pkg::TGT_W-1:0]      ramped_setpoint,
  output logic                                   clamped_flag
);
  import rpid_pkg::*;

  localparam int LIM_W  = $clog2(DRIVE_FULL + 1);
  localparam int LIMC_W = (LIM_W > LIMIT_W) ? LIM_W : LIMIT_W;
  localparam int Q_W    = $clog2(PWM_TOP + 1);
  localparam int NUM_W  = $clog2(DRIVE_FULL * PWM_TOP + 1);
  localparam int SH     = NUM_W;
  localparam logic [SH:0] RECIP = (SH+1)'((64'd1 << SH) / DRIVE_FULL);
  localparam int OPW    = (SH + 2 > GAIN_W + 1) ? SH + 2 : GAIN_W + 1;
  localparam int PW     = 2 * OPW;
  localparam int RAW_W  = PW - FRAC_W;
  localparam int RMP_W  = TGT_W + 2;
  localparam int ISUM_W = GAIN_W + 1;
  localparam int DIF_W  = ERR_W + 1;

  logic signed [GAIN_W-1:0] kp, ki, kd;
  assign kp = cfg.gain_prop;
  assign ki = cfg.gain_int_scaled;
  assign kd = cfg.gain_der_scaled;

  // tick state
  logic signed [TGT_W-1:0]   setpoint;
  logic signed [GAIN_W-1:0]  integ;
  logic signed [ERR_W-1:0]   last_err;

  logic signed [SPEED_W-1:0] speed_q;
  logic signed [ERR_W-1:0]   err;
  logic signed [DIF_W-1:0]   diff;
  logic signed [PW-1:0]      prod;
  logic signed [PW-1:0]      acc;
  logic signed [LIM_W:0]     drive;
  logic [LIM_W-1:0]          mag;
  logic                      clamped;
  logic [NUM_W-1:0]          num;
  logic [Q_W-1:0]            quo;

  // ramp
  logic signed [TGT_W-1:0] setpoint_next;
  logic signed [RMP_W-1:0] spx, tx, stepx, up, dn;

  always_comb begin
    spx   = RMP_W'(setpoint);
    tx    = RMP_W'(cfg.target_speed);
    stepx = RMP_W'(cfg.ramp_step);
    up    = spx + stepx;
    dn    = spx - stepx;
    if (tx > spx) begin
      setpoint_next = (up > tx) ? cfg.target_speed : up[TGT_W-1:0];
    end else if (tx < spx) begin
      setpoint_next = (dn < tx) ? cfg.target_speed : dn[TGT_W-1:0];
    end else begin
      setpoint_next = setpoint;
    end
  end

  // error, integral, difference
  logic signed [ERR_W-1:0]  err_next;
  logic signed [ISUM_W-1:0] isum;
  logic signed [GAIN_W-1:0] integ_next;
  logic signed [DIF_W-1:0]  diff_next;

  always_comb begin
    err_next  = ERR_W'(setpoint) - ERR_W'(speed_q);
    isum      = ISUM_W'(integ) + ISUM_W'(err_next);
    diff_next = DIF_W'(err_next) - DIF_W'(last_err);
    if (isum[ISUM_W-1] != isum[ISUM_W-2]) begin
      integ_next = isum[ISUM_W-1] ? {1'b1, {(GAIN_W-1){1'b0}}} : {1'b0, {(GAIN_W-1){1'b1}}};
    end else begin
      integ_next = isum[GAIN_W-1:0];
    end
  end

  // shared multiplier
  logic signed [OPW-1:0] ma, mb;
  logic [LIM_W-1:0]      span;

  assign span = LIM_W'(DRIVE_FULL) - mag;

  always_comb begin
    case (cmd.mul_sel)
      MUL_KP: begin
        ma = OPW'(kp);
        mb = OPW'(err);
      end
      MUL_KI: begin
        ma = OPW'(ki);
        mb = OPW'(integ);
      end
      MUL_KD: begin
        ma = OPW'(kd);
        mb = OPW'(diff);
      end
      MUL_NUM: begin
        ma = OPW'(span);
        mb = OPW'(PWM_TOP);
      end
      MUL_REC: begin
        ma = OPW'(prod[NUM_W-1:0]);
        mb = OPW'(RECIP);
      end
      MUL_QD: begin
        ma = OPW'(quo);
        mb = OPW'(DRIVE_FULL);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // truncate toward zero and clamp
  logic [LIMC_W-1:0]       lim_full;
  logic [LIM_W-1:0]        lim;
  logic signed [RAW_W-1:0] lim_s, raw, neg_raw;
  logic                    rnd;
  logic signed [LIM_W:0]   drive_next;
  logic [LIM_W-1:0]        mag_next;
  logic                    clamped_next;

  always_comb begin
    lim_full = (LIMC_W'(cfg.drive_limit) > LIMC_W'(DRIVE_FULL)) ?
               LIMC_W'(DRIVE_FULL) : LIMC_W'(cfg.drive_limit);
    lim      = lim_full[LIM_W-1:0];
    lim_s    = RAW_W'({1'b0, lim});
    rnd      = acc[PW-1] && (|acc[FRAC_W-1:0]);
    raw      = acc[PW-1:FRAC_W] + RAW_W'(rnd);
    neg_raw  = -raw;
    if (raw > lim_s) begin
      drive_next   = {1'b0, lim};
      mag_next     = lim;
      clamped_next = 1'b1;
    end else if (raw < -lim_s) begin
      drive_next   = -{1'b0, lim};
      mag_next     = lim;
      clamped_next = 1'b1;
    end else begin
      drive_next   = raw[LIM_W:0];
      mag_next     = raw[RAW_W-1] ? neg_raw[LIM_W-1:0] : raw[LIM_W-1:0];
      clamped_next = 1'b0;
    end
  end

  // quotient correction: estimate is exact or one low
  logic [NUM_W-1:0] rem;
  logic [Q_W-1:0]   quo_fix;
  logic [Q_W-1:0]   pwm_top_c;

  always_comb begin
    rem       = num - prod[NUM_W-1:0];
    quo_fix   = quo + Q_W'(rem >= NUM_W'(DRIVE_FULL));
    pwm_top_c = Q_W'(PWM_TOP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint <= '0;
      integ    <= '0;
      last_err <= '0;
    end else begin
      if (cmd.accept) begin
        setpoint <= setpoint_next;
      end
      if (cmd.err) begin
        integ    <= integ_next;
        last_err <= err_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      speed_q <= speed_rpm;
    end
    if (cmd.err) begin
      err  <= err_next;
      diff <= diff_next;
    end
    if (cmd.mul_sel != MUL_NONE) begin
      prod <= ma * mb;
    end
    case (cmd.acc_op)
      ACC_LOAD: acc <= prod;
      ACC_ADD:  acc <= acc + prod;
      default: ;
    endcase
    if (cmd.clamp) begin
      drive   <= drive_next;
      mag     <= mag_next;
      clamped <= clamped_next;
    end
    if (cmd.n_load) begin
      num <= prod[NUM_W-1:0];
    end
    if (cmd.q_load) begin
      quo <= prod[SH+Q_W-1:SH];
    end
    if (cmd.out_load) begin
      drive_value     <= DRIVE_W'(drive);
      ramped_setpoint <= setpoint;
      clamped_flag    <= clamped;
      if (drive[LIM_W]) begin
        compare_a <= CMP_W'(quo_fix);
        compare_b <= CMP_W'(pwm_top_c);
      end else begin
        compare_a <= CMP_W'(pwm_top_c);
        compare_b <= CMP_W'(quo_fix);
      end
    end
  end

endmodule

`default_nettype wire
